[src/odo_pkg.sv]
// Shared types, constants and tables for the odometry pose integrator.
// Depends on nothing; every other file imports it.
`default_nettype none

package odo_pkg;

  // Field widths that are fixed by the interface
  localparam int POSE_BITS_DEF  = 32;
  localparam int STEP_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int RECIP_W        = 24;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 24'd83443;

  // Opcode of an input word
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // CORDIC: angle in 2^-32 turn units, vector in Q30
  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int ZW           = 32;
  localparam int VW           = 32;
  localparam logic signed [VW-1:0] CORDIC_INIT = 32'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_ANGLE,
    ST_ROTATE,
    ST_MUL_C,
    ST_MUL_S,
    ST_ROUND,
    ST_COMMIT
  } odo_state_e;

  typedef struct packed {
    logic              accept;
    logic              mul_p;
    logic              angle;
    logic              rotate;
    logic              mul_c;
    logic              mul_s;
    logic              round_y;
    logic              commit;
    logic [ITER_W-1:0] iter;
  } odo_cmd_t;

  typedef struct packed {
    logic is_load;
  } odo_status_t;

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:    v = 32'sd536870912;
      4'd1:    v = 32'sd316933406;
      4'd2:    v = 32'sd167458907;
      4'd3:    v = 32'sd85004756;
      4'd4:    v = 32'sd42667331;
      4'd5:    v = 32'sd21354465;
      4'd6:    v = 32'sd10680350;
      4'd7:    v = 32'sd5340245;
      4'd8:    v = 32'sd2670163;
      4'd9:    v = 32'sd1335087;
      4'd10:   v = 32'sd667544;
      4'd11:   v = 32'sd333772;
      4'd12:   v = 32'sd166886;
      4'd13:   v = 32'sd83443;
      4'd14:   v = 32'sd41722;
      4'd15:   v = 32'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/odo_ctrl.sv]
// Sequencer for the odometry pose integrator: state machine, CORDIC
// iteration count and output valid. Depends on odo_pkg.
`default_nettype none

module odo_ctrl
  import odo_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire odo_status_t status_i,
  output odo_cmd_t         cmd_o
);

  odo_state_e        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  // Output slot is free when empty or being taken at this edge
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_MUL_P;
      ST_MUL_P:  state_d = status_i.is_load ? ST_COMMIT : ST_ANGLE;
      ST_ANGLE: begin
        state_d = ST_ROTATE;
        iter_d  = '0;
      end
      ST_ROTATE: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(CORDIC_ITERS - 1)) state_d = ST_MUL_C;
      end
      ST_MUL_C:  state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_COMMIT;
      ST_COMMIT: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.iter    = iter_q;
    cmd_o.accept  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_p   = (state_q == ST_MUL_P);
    cmd_o.angle   = (state_q == ST_ANGLE);
    cmd_o.rotate  = (state_q == ST_ROTATE);
    cmd_o.mul_c   = (state_q == ST_MUL_C);
    cmd_o.mul_s   = (state_q == ST_MUL_S);
    cmd_o.round_y = (state_q == ST_ROUND);
    cmd_o.commit  = (state_q == ST_COMMIT) && slot_free;
    in_stall_o    = (state_q != ST_IDLE);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("commit while output word still stalled");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("output valid rose without a commit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_MUL_P))
    else $error("accepted word did not start the sequence");

  a_rotate_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ANGLE) |=> (state_q == ST_ROTATE && iter_q == '0))
    else $error("rotation did not start at iteration zero");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && !slot_free) |=> (state_q == ST_COMMIT && in_stall_o))
    else $error("left commit state without delivering");

endmodule

`default_nettype wire

[src/odo_datapath.sv]
// Datapath of the odometry pose integrator: pose and reciprocal registers,
// shared multiplier, CORDIC rotator, rounding and saturation. Depends on odo_pkg.
`default_nettype none

module odo_datapath
  import odo_pkg::*;
#(
  parameter int POSE_BITS  = POSE_BITS_DEF,
  parameter int STEP_BITS  = STEP_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire odo_cmd_t                      cmd_i,
  output odo_status_t                        status_o,
  input  wire logic                          cfg_we_i,
  input  wire logic        [RECIP_W-1:0]     cfg_wdata_i,
  input  wire logic                          opcode_i,
  input  wire logic signed [STEP_BITS-1:0]   left_dist_i,
  input  wire logic signed [STEP_BITS-1:0]   right_dist_i,
  input  wire logic signed [POSE_BITS-1:0]   load_x_i,
  input  wire logic signed [POSE_BITS-1:0]   load_y_i,
  input  wire logic signed [ANGLE_BITS-1:0]  load_heading_i,
  output logic signed      [POSE_BITS-1:0]   pos_x_o,
  output logic signed      [POSE_BITS-1:0]   pos_y_o,
  output logic signed      [ANGLE_BITS-1:0]  heading_o
);

  localparam int SW     = STEP_BITS + 1;
  localparam int MUL_W  = VW + SW;
  localparam int RND_W  = (MUL_W > ANGLE_BITS + 18) ? MUL_W : ANGLE_BITS + 18;
  localparam int DXW    = MUL_W - 31;
  localparam int SUM_W  = ((POSE_BITS > DXW) ? POSE_BITS : DXW) + 1;
  localparam int ZPAD   = ZW - ANGLE_BITS;

  localparam logic signed [POSE_BITS-1:0] POSE_MAX = {1'b0, {(POSE_BITS-1){1'b1}}};
  localparam logic signed [POSE_BITS-1:0] POSE_MIN = {1'b1, {(POSE_BITS-1){1'b0}}};
  localparam logic signed [ZW-1:0]        QUARTER  = 32'sd1073741824;

  // Pose state and configuration
  logic signed [POSE_BITS-1:0]  pos_x_q, pos_y_q;
  logic signed [ANGLE_BITS-1:0] heading_q;
  logic        [RECIP_W-1:0]    recip_q;

  // Latched input word
  logic                         load_q;
  logic signed [SW-1:0]         diff_q, sum_q;
  logic signed [POSE_BITS-1:0]  ld_x_q, ld_y_q;
  logic signed [ANGLE_BITS-1:0] ld_h_q;

  // Working registers
  logic signed [MUL_W-1:0]      prod_q;
  logic signed [ANGLE_BITS-1:0] dth_q;
  logic signed [VW-1:0]         x_q, y_q;
  logic signed [ZW-1:0]         z_q;
  logic                         neg_q;
  logic signed [DXW-1:0]        dx_q, dy_q;

  // Shared multiplier
  logic signed [VW-1:0]    mul_a;
  logic signed [SW-1:0]    mul_b;
  logic signed [MUL_W-1:0] mul_p;

  always_comb begin
    mul_a = neg_q ? -x_q : x_q;
    mul_b = sum_q;
    if (cmd_i.mul_p) begin
      mul_a = $signed(VW'(recip_q));
      mul_b = diff_q;
    end else if (cmd_i.mul_s) begin
      mul_a = neg_q ? -y_q : y_q;
    end
  end
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  // Heading step and half step, rounded half up, wrapped
  logic signed [RND_W-1:0]      p_ext, p_r16, p_r17;
  logic signed [ANGLE_BITS-1:0] dth, half, mid;
  logic signed [ZW-1:0]         z_raw, z_init;
  logic                         fold;

  assign p_ext  = RND_W'(prod_q);
  assign p_r16  = p_ext + (RND_W'(1) << 15);
  assign p_r17  = p_ext + (RND_W'(1) << 16);
  assign dth    = p_r16[16 +: ANGLE_BITS];
  assign half   = p_r17[17 +: ANGLE_BITS];
  assign mid    = heading_q + half;
  assign z_raw  = {mid, {ZPAD{1'b0}}};
  assign fold   = (z_raw > QUARTER) || (z_raw < -QUARTER);
  // Moving by half a turn flips the top bit of the binary angle
  assign z_init = fold ? {~z_raw[ZW-1], z_raw[ZW-2:0]} : z_raw;

  // One CORDIC rotation step
  logic signed [VW-1:0] x_sh, y_sh;
  logic signed [ZW-1:0] atan_v;
  logic                 dir_pos;

  assign x_sh    = x_q >>> cmd_i.iter;
  assign y_sh    = y_q >>> cmd_i.iter;
  assign atan_v  = atan_entry(cmd_i.iter);
  assign dir_pos = !z_q[ZW-1];

  // Rounded displacement from the product register
  logic signed [MUL_W-1:0] prod_rnd;
  logic signed [DXW-1:0]   disp;

  assign prod_rnd = prod_q + (MUL_W'(1) << 30);
  assign disp     = prod_rnd[31 +: DXW];

  // Saturating position update
  logic signed [SUM_W-1:0]     xs, ys;
  logic signed [POSE_BITS-1:0] x_new, y_new;

  assign xs = SUM_W'(pos_x_q) + SUM_W'(dx_q);
  assign ys = SUM_W'(pos_y_q) + SUM_W'(dy_q);

  always_comb begin
    if (xs > SUM_W'(POSE_MAX))      x_new = POSE_MAX;
    else if (xs < SUM_W'(POSE_MIN)) x_new = POSE_MIN;
    else                            x_new = xs[POSE_BITS-1:0];
    if (ys > SUM_W'(POSE_MAX))      y_new = POSE_MAX;
    else if (ys < SUM_W'(POSE_MIN)) y_new = POSE_MIN;
    else                            y_new = ys[POSE_BITS-1:0];
  end

  // Control state: pose and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      heading_q <= '0;
      recip_q   <= RECIP_RESET;
    end else begin
      if (cfg_we_i) recip_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        if (load_q) begin
          pos_x_q   <= ld_x_q;
          pos_y_q   <= ld_y_q;
          heading_q <= ld_h_q;
        end else begin
          pos_x_q   <= x_new;
          pos_y_q   <= y_new;
          heading_q <= heading_q + dth_q;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      load_q <= (opcode_i == OP_LOAD);
      diff_q <= SW'(right_dist_i) - SW'(left_dist_i);
      sum_q  <= SW'(right_dist_i) + SW'(left_dist_i);
      ld_x_q <= load_x_i;
      ld_y_q <= load_y_i;
      ld_h_q <= load_heading_i;
    end
    if (cmd_i.mul_p || cmd_i.mul_c || cmd_i.mul_s) prod_q <= mul_p;
    if (cmd_i.angle) begin
      dth_q <= dth;
      z_q   <= z_init;
      neg_q <= fold;
      x_q   <= CORDIC_INIT;
      y_q   <= '0;
    end
    if (cmd_i.rotate) begin
      if (dir_pos) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.mul_s)   dx_q <= disp;
    if (cmd_i.round_y) dy_q <= disp;
  end

  assign status_o.is_load = load_q;
  assign pos_x_o          = pos_x_q;
  assign pos_y_o          = pos_y_q;
  assign heading_o        = heading_q;

endmodule

`default_nettype wire

[src/odometry_pose_integrator.sv]
// Top level of the differential-drive odometry pose integrator.
// Depends on odo_pkg, odo_ctrl and odo_datapath.
//
// Dead-reckoning pose integrator. Each input word is either a wheel step
// (opcode 0: left and right wheel travel in 2^-14 m) or a pose load
// (opcode 1: x, y and heading taken as given). A wheel step turns the
// heading by (right - left) * track_width_recip / 2^16 binary-angle units,
// rounded half up, and moves the position by the mean wheel travel along
// the mid-step heading; sine and cosine come from a 16-iteration CORDIC
// rotator that is run one iteration per cycle. Heading wraps as a binary
// angle (half of full scale equals pi); x and y saturate at the limits of
// their width. Every input word yields exactly one output word holding the
// pose after that word. A wheel step occupies the block from the accepting
// edge to the edge that loads its result, through the 16 CORDIC iterations
// plus one multiply for the heading change, one for each of the two
// displacements, and setup, rounding and commit steps; a pose load goes
// from its multiply step straight to commit. Input stall is high while a
// word is being processed, so one word is in flight at a time; a finished
// word waits in the output register and does not stall the input side, but
// the next word cannot commit until that output word is taken. The
// track-width reciprocal is written through cfg_we_i / cfg_wdata_i and
// resets to 83443; write it only while the block is idle.
`default_nettype none

module odometry_pose_integrator
  import odo_pkg::*;
#(
  parameter int POSE_BITS  = POSE_BITS_DEF,
  parameter int STEP_BITS  = STEP_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: track width reciprocal
  input  wire logic                          cfg_we_i,
  input  wire logic        [RECIP_W-1:0]     cfg_wdata_i,
  // Input words
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          opcode_i,
  input  wire logic signed [STEP_BITS-1:0]   left_dist_i,
  input  wire logic signed [STEP_BITS-1:0]   right_dist_i,
  input  wire logic signed [POSE_BITS-1:0]   load_x_i,
  input  wire logic signed [POSE_BITS-1:0]   load_y_i,
  input  wire logic signed [ANGLE_BITS-1:0]  load_heading_i,
  // Output words
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed      [POSE_BITS-1:0]   pos_x_o,
  output logic signed      [POSE_BITS-1:0]   pos_y_o,
  output logic signed      [ANGLE_BITS-1:0]  heading_o
);

  odo_cmd_t    cmd;
  odo_status_t status;

  // Sequencer: accepts a word, steps the datapath, holds the result valid
  odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: the pose registers double as the output register, since they
  // only change at commit, which waits for the previous word to be taken
  odo_datapath #(
    .POSE_BITS  (POSE_BITS),
    .STEP_BITS  (STEP_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .left_dist_i    (left_dist_i),
    .right_dist_i   (right_dist_i),
    .load_x_i       (load_x_i),
    .load_y_i       (load_y_i),
    .load_heading_i (load_heading_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o)
  );

endmodule

`default_nettype wire
